// ===== hdl/fct_pkg.sv =====
// Shared types, widths and codes for the frustum cull test block.
package fct_pkg;

  // Number of plane registers and planes that take part in the test
  localparam int REG_COUNT   = 6;
  localparam int PLANE_COUNT = 6;
  localparam int LANE_COUNT  = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;
  localparam int REG_IDX_W   = $clog2(REG_COUNT);
  localparam int PLANE_W     = 64;

  // Stream payload widths
  localparam int COORD_W     = 16;
  localparam int RADIUS_W    = 15;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 8;
  localparam int VERDICT_W   = 2;

  // Object kinds carried on in_tuser
  localparam logic FUNC_SPHERE = 1'b0;
  localparam logic FUNC_BOX    = 1'b1;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_INSIDE     = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_INTERSECTS = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COORD_W:0]   coord_sum_t;
  typedef logic signed [32:0]        dist_prod_t;
  typedef logic signed [34:0]        lim_prod_t;
  typedef logic signed [35:0]        plane_sum_t;

  // Per-lane result of the plane comparison
  typedef struct packed {
    logic outside;
    logic not_inside;
  } lane_flags_t;

  // Pipeline load enables for the lane stages
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

// ===== hdl/fct_plane_lane.sv =====
// One plane of the test: product stage, then sum and compare stage.
module fct_plane_lane (
  input  logic                          clk,
  input  fct_pkg::stage_en_t            en,
  input  logic [fct_pkg::PLANE_W-1:0]   plane,
  input  logic                          func_s0,
  input  fct_pkg::coord_t               pos_s0 [3],
  input  fct_pkg::coord_t               corner_s0 [3],
  input  logic                          func_s1,
  input  logic [fct_pkg::RADIUS_W-1:0]  radius_s1,
  output fct_pkg::lane_flags_t          flags_r
);

  fct_pkg::coord_t     n [3];
  fct_pkg::coord_sum_t a [3];
  fct_pkg::coord_sum_t e [3];
  logic signed [17:0]  n_mag [3];
  fct_pkg::dist_prod_t pd_nxt [3];
  fct_pkg::lim_prod_t  pl_nxt [3];
  fct_pkg::dist_prod_t pd_r [3];
  fct_pkg::lim_prod_t  pl_r [3];

  fct_pkg::coord_t     d;
  fct_pkg::plane_sum_t d_term;
  fct_pkg::plane_sum_t dist_sum;
  fct_pkg::plane_sum_t lim;
  fct_pkg::lane_flags_t flags_nxt;

  // Build per-axis operands: box works in doubled units on min+max
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n[i] = plane[16*i +: 16];
      if (func_s0 == fct_pkg::FUNC_BOX) begin
        a[i] = fct_pkg::coord_sum_t'(pos_s0[i]) + fct_pkg::coord_sum_t'(corner_s0[i]);
      end else begin
        a[i] = fct_pkg::coord_sum_t'(pos_s0[i]);
      end
      e[i]      = fct_pkg::coord_sum_t'(corner_s0[i]) - fct_pkg::coord_sum_t'(pos_s0[i]);
      n_mag[i]  = n[i][15] ? -(18'(n[i])) : 18'(n[i]);
      pd_nxt[i] = fct_pkg::dist_prod_t'(n[i]) * fct_pkg::dist_prod_t'(a[i]);
      pl_nxt[i] = fct_pkg::lim_prod_t'(n_mag[i]) * fct_pkg::lim_prod_t'(e[i]);
    end
  end

  // Hold the products
  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int i = 0; i < 3; i++) begin
        pd_r[i] <= pd_nxt[i];
        pl_r[i] <= pl_nxt[i];
      end
    end
  end

  // Sum the distance and the limit, then compare both ways
  always_comb begin
    d = plane[63:48];
    if (func_s1 == fct_pkg::FUNC_BOX) begin
      d_term = fct_pkg::plane_sum_t'(d) <<< 15;
      lim    = fct_pkg::plane_sum_t'(pl_r[0]) + fct_pkg::plane_sum_t'(pl_r[1])
             + fct_pkg::plane_sum_t'(pl_r[2]);
    end else begin
      d_term = fct_pkg::plane_sum_t'(d) <<< 14;
      lim    = fct_pkg::plane_sum_t'({1'b0, radius_s1}) <<< 14;
    end
    dist_sum = fct_pkg::plane_sum_t'(pd_r[0]) + fct_pkg::plane_sum_t'(pd_r[1])
             + fct_pkg::plane_sum_t'(pd_r[2]) + d_term;
    flags_nxt.outside    = dist_sum < -lim;
    flags_nxt.not_inside = dist_sum < lim;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      flags_r <= flags_nxt;
    end
  end

endmodule

// ===== hdl/fct_verdict.sv =====
// Combines the per-plane flags into the verdict and holds it for the output.
module fct_verdict (
  input  logic                            clk,
  input  logic                            en,
  input  fct_pkg::lane_flags_t            flags [fct_pkg::LANE_COUNT],
  output logic [fct_pkg::VERDICT_W-1:0]   verdict_r
);

  logic any_out;
  logic any_cross;
  logic [fct_pkg::VERDICT_W-1:0] verdict_nxt;

  // Any plane with the object behind it wins over everything else
  always_comb begin
    any_out   = 1'b0;
    any_cross = 1'b0;
    for (int l = 0; l < fct_pkg::LANE_COUNT; l++) begin
      any_out   = any_out | flags[l].outside;
      any_cross = any_cross | flags[l].not_inside;
    end
    if (any_out) begin
      verdict_nxt = fct_pkg::VERDICT_OUTSIDE;
    end else if (any_cross) begin
      verdict_nxt = fct_pkg::VERDICT_INTERSECTS;
    end else begin
      verdict_nxt = fct_pkg::VERDICT_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      verdict_r <= verdict_nxt;
    end
  end

endmodule

// ===== hdl/frustum_cull_test.sv =====
// Frustum cull test top level: plane registers, input stage and pipeline control.
// Classifies one sphere, point or axis-aligned box per beat against the plane
// registers as outside, inside or intersecting. The block accepts one beat
// every cycle while the output is not stalled; each beat passes through the
// four register stages (input, products, plane sums, verdict) on its way to the
// output. Stages only move when the next one is free, so a stalled output
// holds its result while the input side keeps filling the empty stages.
// Plane registers may only be written while no beat is in flight.
module frustum_cull_test (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x, pos_y, pos_z, corner_x, corner_y, corner_z, radius, zero pad
  input  logic [fct_pkg::IN_DATA_W-1:0]     in_tdata,
  // func
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // verdict, zero pad
  output logic [fct_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [fct_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [fct_pkg::PLANE_W-1:0]       cfg_wdata
);

  logic [fct_pkg::PLANE_W-1:0] plane_r [fct_pkg::REG_COUNT];

  logic v0_r, v1_r, v2_r, v3_r;
  logic en0, en1, en2, en3;

  logic                          func_s0_r;
  fct_pkg::coord_t               pos_s0_r [3];
  fct_pkg::coord_t               corner_s0_r [3];
  logic [fct_pkg::RADIUS_W-1:0]  radius_s0_r;
  logic                          func_s1_r;
  logic [fct_pkg::RADIUS_W-1:0]  radius_s1_r;

  fct_pkg::stage_en_t            lane_en;
  fct_pkg::lane_flags_t          flags [fct_pkg::LANE_COUNT];
  logic [fct_pkg::VERDICT_W-1:0] verdict;

  // Write plane registers; drop writes past the last register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fct_pkg::REG_COUNT; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_we && (32'(cfg_index) < fct_pkg::REG_COUNT)) begin
      plane_r[cfg_index] <= cfg_wdata;
    end
  end

  // A stage loads when it is empty or the next stage takes its beat
  assign en3 = !v3_r || out_tready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_tready = en0;

  assign lane_en.s1 = en1;
  assign lane_en.s2 = en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_tvalid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Input stage: unpack the beat
  always_ff @(posedge clk) begin
    if (en0) begin
      func_s0_r      <= in_tuser;
      pos_s0_r[0]    <= in_tdata[15:0];
      pos_s0_r[1]    <= in_tdata[31:16];
      pos_s0_r[2]    <= in_tdata[47:32];
      corner_s0_r[0] <= in_tdata[63:48];
      corner_s0_r[1] <= in_tdata[79:64];
      corner_s0_r[2] <= in_tdata[95:80];
      radius_s0_r    <= in_tdata[110:96];
    end
  end

  // Carry the kind and radius alongside the products
  always_ff @(posedge clk) begin
    if (en1) begin
      func_s1_r   <= func_s0_r;
      radius_s1_r <= radius_s0_r;
    end
  end

  for (genvar l = 0; l < fct_pkg::LANE_COUNT; l++) begin : g_lane
    fct_plane_lane u_lane (
      .clk       (clk),
      .en        (lane_en),
      .plane     (plane_r[l]),
      .func_s0   (func_s0_r),
      .pos_s0    (pos_s0_r),
      .corner_s0 (corner_s0_r),
      .func_s1   (func_s1_r),
      .radius_s1 (radius_s1_r),
      .flags_r   (flags[l])
    );
  end

  fct_verdict u_verdict (
    .clk       (clk),
    .en        (en3),
    .flags     (flags),
    .verdict_r (verdict)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = fct_pkg::OUT_DATA_W'(verdict);

endmodule

// ===== hdl/fct_checker.sv =====
// Port-level checks for the frustum cull test, bound to the top level.
module fct_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [fct_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Only the three verdict codes appear, pad bits stay zero
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == 8'(fct_pkg::VERDICT_OUTSIDE)) ||
                   (out_tdata == 8'(fct_pkg::VERDICT_INSIDE)) ||
                   (out_tdata == 8'(fct_pkg::VERDICT_INTERSECTS)))
    else $error("bad verdict code");

  // A draining output never blocks the input
  a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  // An accepted beat reaches the output when the output stays ready while it moves through the stages
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready ##1 out_tready
      |=> out_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/frustum_cull_test_tb.sv =====
// Self-checking stream testbench for the frustum cull test block.
`timescale 1ns / 1ps

module frustum_cull_test_tb;

  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 108;
  localparam int HOLD_CYCLES = 64;
  localparam int PIPE_DEPTH  = 4;
  localparam int Q_ONE       = 16384;
  localparam int DIR_ROWS    = 12;
  localparam int WATCHDOG_NS = 2_000_000;

  // Plane register indexes
  localparam int REG_NEAR   = 0;
  localparam int REG_LEFT   = 1;
  localparam int REG_RIGHT  = 2;
  localparam int REG_TOP    = 3;
  localparam int REG_BOTTOM = 4;
  localparam int REG_FAR    = 5;

  typedef enum int {PSET_CUBE, PSET_TILTED, PSET_RAW, PSET_SPARSE, PSET_MIN, PSET_MAX}
    plane_set_t;
  typedef enum int {SINK_OPEN, SINK_BUSY, SINK_SPARSE, SINK_COIN} sink_mode_t;

  typedef struct packed {
    logic                         func;
    fct_pkg::coord_t              px, py, pz;
    fct_pkg::coord_t              qx, qy, qz;
    logic [fct_pkg::RADIUS_W-1:0] rad;
  } cull_obj_t;

  typedef struct packed {
    cull_obj_t                      obj;
    logic [fct_pkg::VERDICT_W-1:0]  at_reset;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [fct_pkg::IN_DATA_W-1:0]   in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [fct_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic                            cfg_we;
  logic [fct_pkg::REG_IDX_W-1:0]   cfg_index;
  logic [fct_pkg::PLANE_W-1:0]     cfg_wdata;

  // Plane words as the block holds them, and the next set to load
  logic [fct_pkg::PLANE_W-1:0] plane_words [fct_pkg::REG_COUNT] = '{default: '0};
  logic [fct_pkg::PLANE_W-1:0] next_planes [fct_pkg::REG_COUNT] = '{default: '0};

  logic [fct_pkg::VERDICT_W-1:0] expected_verdicts [$];

  int error_count;
  int burst_left;
  int input_stall_cycles;
  int holds_asked;
  int holds_done;
  int settings_loaded;
  int n_spheres, n_points, n_boxes;
  int verdict_seen [3];

  // Directed objects; the last column is the verdict with all planes zero
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{fct_pkg::FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 10}, fct_pkg::VERDICT_INTERSECTS},
    '{'{fct_pkg::FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 0}, fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::FUNC_SPHERE, 200, 0, 0, 0, 0, 0, 10}, fct_pkg::VERDICT_INTERSECTS},
    '{'{fct_pkg::FUNC_SPHERE, 95, 0, 0, 0, 0, 0, 10}, fct_pkg::VERDICT_INTERSECTS},
    '{'{fct_pkg::FUNC_SPHERE, 100, 0, 0, 0, 0, 0, 0}, fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::FUNC_BOX, -10, -10, -10, 10, 10, 10, 0}, fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::FUNC_BOX, 90, -10, -10, 110, 10, 10, 0}, fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::FUNC_BOX, 150, 150, 150, 160, 160, 160, 0}, fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::FUNC_BOX, 10, 10, 10, -10, -10, -10, 0}, fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::FUNC_SPHERE, -32768, -32768, -32768, 32767, 32767, 32767, 32767},
      fct_pkg::VERDICT_INTERSECTS},
    '{'{fct_pkg::FUNC_SPHERE, 32767, 32767, 32767, 0, 0, 0, 0}, fct_pkg::VERDICT_INSIDE},
    '{'{fct_pkg::FUNC_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 32767},
      fct_pkg::VERDICT_INSIDE}
  };

  frustum_cull_test u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Exact plane classification in 2^14-scaled integer units
  function automatic logic [fct_pkg::VERDICT_W-1:0] classify_object(input cull_obj_t o);
    longint nx, ny, nz, off, dist_val, lim;
    logic   all_in;
    int     k;
    all_in = 1'b1;
    for (k = 0; k < fct_pkg::LANE_COUNT; k++) begin
      nx  = longint'($signed(plane_words[k][15:0]));
      ny  = longint'($signed(plane_words[k][31:16]));
      nz  = longint'($signed(plane_words[k][47:32]));
      off = longint'($signed(plane_words[k][63:48]));
      if (o.func == fct_pkg::FUNC_BOX) begin
        // doubled units: center sum against |n| dot full extent
        dist_val = nx * (longint'($signed(o.px)) + longint'($signed(o.qx)))
                 + ny * (longint'($signed(o.py)) + longint'($signed(o.qy)))
                 + nz * (longint'($signed(o.pz)) + longint'($signed(o.qz)))
                 + off * 32768;
        lim  = ((nx < 0) ? -nx : nx) * (longint'($signed(o.qx)) - longint'($signed(o.px)))
             + ((ny < 0) ? -ny : ny) * (longint'($signed(o.qy)) - longint'($signed(o.py)))
             + ((nz < 0) ? -nz : nz) * (longint'($signed(o.qz)) - longint'($signed(o.pz)));
      end else begin
        dist_val = nx * longint'($signed(o.px)) + ny * longint'($signed(o.py))
                 + nz * longint'($signed(o.pz)) + off * Q_ONE;
        lim  = longint'(o.rad) * Q_ONE;
      end
      if (dist_val < -lim) return fct_pkg::VERDICT_OUTSIDE;
      if (dist_val < lim) all_in = 1'b0;
    end
    return all_in ? fct_pkg::VERDICT_INSIDE : fct_pkg::VERDICT_INTERSECTS;
  endfunction

  function automatic logic [fct_pkg::IN_DATA_W-1:0] pack_object(input cull_obj_t o);
    return {1'b0, o.rad, o.qz, o.qy, o.qx, o.pz, o.py, o.px};
  endfunction

  function automatic logic [fct_pkg::PLANE_W-1:0] pack_plane(input int nx, ny, nz, off);
    return {16'(off), 16'(nz), 16'(ny), 16'(nx)};
  endfunction

  // span 0 means the whole 16-bit range
  function automatic fct_pkg::coord_t rand_coord(input int span);
    if (span == 0) return fct_pkg::coord_t'($urandom);
    return fct_pkg::coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic cull_obj_t random_object();
    cull_obj_t o;
    int        sel;
    int        span;
    sel  = $urandom_range(0, 19);
    span = (sel < 10) ? 160 : (sel < 17) ? 4096 : 0;
    o.func = ($urandom_range(0, 1) == 0) ? fct_pkg::FUNC_SPHERE : fct_pkg::FUNC_BOX;
    o.px = rand_coord(span);
    o.py = rand_coord(span);
    o.pz = rand_coord(span);
    if (o.func == fct_pkg::FUNC_SPHERE) begin
      // corners are don't-care for spheres; fill with noise
      o.qx = fct_pkg::coord_t'($urandom);
      o.qy = fct_pkg::coord_t'($urandom);
      o.qz = fct_pkg::coord_t'($urandom);
      sel = $urandom_range(0, 9);
      if (sel < 2)
        o.rad = '0;
      else if (sel < 8)
        o.rad = fct_pkg::RADIUS_W'($urandom_range(0, (span == 0) ? 32767 : span));
      else
        o.rad = fct_pkg::RADIUS_W'($urandom);
    end else begin
      o.rad = fct_pkg::RADIUS_W'($urandom);
      if ($urandom_range(0, 6) != 0) begin
        // mostly well-formed box: max corner at or above min corner unless the 16-bit sum wraps
        o.qx = fct_pkg::coord_t'(o.px + fct_pkg::coord_t'(
                 $urandom_range(0, (span == 0) ? 65535 : span)));
        o.qy = fct_pkg::coord_t'(o.py + fct_pkg::coord_t'(
                 $urandom_range(0, (span == 0) ? 65535 : span)));
        o.qz = fct_pkg::coord_t'(o.pz + fct_pkg::coord_t'(
                 $urandom_range(0, (span == 0) ? 65535 : span)));
      end else begin
        o.qx = rand_coord(span);
        o.qy = rand_coord(span);
        o.qz = rand_coord(span);
      end
    end
    return o;
  endfunction

  // Axis-aligned cube frustum, offsets drawn per plane
  task automatic fill_cube(input int d_lo, input int d_hi);
    next_planes[REG_NEAR]   = pack_plane(0, 0, Q_ONE, $urandom_range(d_lo, d_hi));
    next_planes[REG_FAR]    = pack_plane(0, 0, -Q_ONE, $urandom_range(d_lo, d_hi));
    next_planes[REG_LEFT]   = pack_plane(Q_ONE, 0, 0, $urandom_range(d_lo, d_hi));
    next_planes[REG_RIGHT]  = pack_plane(-Q_ONE, 0, 0, $urandom_range(d_lo, d_hi));
    next_planes[REG_TOP]    = pack_plane(0, -Q_ONE, 0, $urandom_range(d_lo, d_hi));
    next_planes[REG_BOTTOM] = pack_plane(0, Q_ONE, 0, $urandom_range(d_lo, d_hi));
  endtask

  task automatic choose_planes(input plane_set_t kind);
    int k;
    case (kind)
      PSET_CUBE: begin
        fill_cube(16, 400);
      end
      PSET_SPARSE: begin
        fill_cube(16, 400);
        for (k = 0; k < fct_pkg::REG_COUNT; k++)
          if ($urandom_range(0, 1) == 0) next_planes[k] = '0;
      end
      PSET_TILTED: begin
        for (k = 0; k < fct_pkg::REG_COUNT; k++)
          next_planes[k] = pack_plane(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                                      int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                                      int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                                      $urandom_range(0, 2000));
      end
      PSET_RAW: begin
        for (k = 0; k < fct_pkg::REG_COUNT; k++) next_planes[k] = {$urandom, $urandom};
      end
      PSET_MIN: begin
        for (k = 0; k < fct_pkg::REG_COUNT; k++) next_planes[k] = {4{16'h8000}};
      end
      default: begin
        for (k = 0; k < fct_pkg::REG_COUNT; k++) next_planes[k] = {4{16'h7FFF}};
      end
    endcase
  endtask

  // Write every index; those past the last plane get junk and must not stick
  task automatic load_planes();
    int idx;
    for (idx = 0; idx < (1 << fct_pkg::REG_IDX_W); idx++) begin
      cfg_we    <= 1'b1;
      cfg_index <= fct_pkg::REG_IDX_W'(idx);
      cfg_wdata <= (idx < fct_pkg::REG_COUNT) ? next_planes[idx] : {$urandom, $urandom};
      @(posedge clk);
      if (idx < fct_pkg::REG_COUNT) plane_words[idx] = next_planes[idx];
    end
    cfg_we <= 1'b0;
    settings_loaded++;
  endtask

  // Offer one beat, first idling a random gap (possibly none) when the current burst is used up
  task automatic send_object(input cull_obj_t o,
                             input logic [fct_pkg::VERDICT_W-1:0] verdict);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= o.func;
    in_tdata  <= pack_object(o);
    do begin
      @(posedge clk);
      if (!in_tready) input_stall_cycles++;
    end while (!in_tready);
    expected_verdicts.push_back(verdict);
    if (o.func == fct_pkg::FUNC_BOX) n_boxes++;
    else if (o.rad == '0) n_points++;
    else n_spheres++;
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Result side: check each beat, stall on a pattern, honor hold-off requests
  initial begin : result_sink
    sink_mode_t                    mode;
    int                            mode_left;
    int                            hold_left;
    logic                          ready_next;
    logic [fct_pkg::VERDICT_W-1:0] want;
    logic [fct_pkg::VERDICT_W-1:0] got;
    mode       = SINK_OPEN;
    mode_left  = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got = out_tdata[fct_pkg::VERDICT_W-1:0];
        if (got < 3) verdict_seen[got]++;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: verdict %0d arrived with none outstanding", $time, got);
          error_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got !== want) begin
            $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, want, got);
            error_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done++;
        hold_left  = HOLD_CYCLES - 1;
        ready_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 120);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:   ready_next = 1'b1;
          SINK_BUSY:   ready_next = ($urandom_range(0, 3) != 0);
          SINK_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
          default:     ready_next = 1'($urandom_range(0, 1));
        endcase
      end
      out_tready <= ready_next;
    end
  end

  initial begin : stimulus
    int         row;
    int         phase;
    int         n;
    int         sel;
    plane_set_t kind;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = fct_pkg::FUNC_SPHERE;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    error_count = 0;
    burst_left  = 0;
    holds_asked = 0;
    holds_done  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass with reset planes: verdicts known outright
    for (row = 0; row < DIR_ROWS; row++)
      send_object(dir_rows[row].obj, dir_rows[row].at_reset);
    settle();

    // Same objects against a 100-unit cube
    fill_cube(100, 100);
    load_planes();
    for (row = 0; row < DIR_ROWS; row++)
      send_object(dir_rows[row].obj, classify_object(dir_rows[row].obj));

    // Random phases, each with its own plane set; extremes come first
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == 0) kind = PSET_MIN;
      else if (phase == 1) kind = PSET_MAX;
      else begin
        sel  = $urandom_range(0, 5);
        kind = (sel > 3) ? PSET_CUBE : plane_set_t'(sel);
      end
      choose_planes(kind);
      load_planes();
      // long output hold-off so the pipe fills and backs up the input
      if (phase % 3 == 1) holds_asked++;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        cull_obj_t o;
        o = random_object();
        send_object(o, classify_object(o));
      end
    end
    settle();

    $display("summary: %0d beats (%0d spheres, %0d points, %0d boxes), %0d plane settings",
             n_spheres + n_points + n_boxes, n_spheres, n_points, n_boxes, settings_loaded);
    $display("summary: outside/inside/intersects %0d/%0d/%0d, %0d input stall cycles",
             verdict_seen[0], verdict_seen[1], verdict_seen[2], input_stall_cycles);
    if (error_count == 0)
      $display("frustum_cull_test_tb: clean");
    else
      $display("frustum_cull_test_tb: errors");
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("%0t: run timed out with %0d results outstanding", $time,
             expected_verdicts.size());
    $display("frustum_cull_test_tb: errors");
    $finish;
  end

endmodule
